// ===== design/ddwd_pkg.sv =====
// Shared types, constants and helper functions for the differential-drive wheel dynamics block.
package ddwd_pkg;

	localparam int ITERATIONS = 10;
	localparam int SIG_ENTRIES = 256;
	localparam int ITER_W = $clog2(ITERATIONS + 1);
	localparam int SIG_IDX_W = $clog2(SIG_ENTRIES);
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK_WIDTH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_TORQUE_SPREAD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT_LEFT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_LEFT_RIGHT = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_RIGHT_RIGHT = 3'd7;

	typedef struct packed {
		logic signed [31:0] velocity_cmd;
		logic signed [31:0] turn_rate_cmd;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] velocity_out;
		logic signed [31:0] turn_rate_out;
	} res_t;

	typedef struct packed {
		logic [30:0] inv_wheel_radius;
		logic [30:0] wheel_radius;
		logic [30:0] half_track_width;
		logic [30:0] inv_track_width;
		logic [30:0] inv_torque_spread;
		logic signed [31:0] gain_left_left;
		logic signed [31:0] gain_left_right;
		logic signed [31:0] gain_right_right;
	} cfg_t;

	typedef logic [SIG_ENTRIES-1:0][31:0] sig_tab_t;

	// Bit-serial restoring division, used only while building the constant table.
	function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Centred sigmoid table built from a Taylor-series exponential.
	function automatic sig_tab_t build_sig_table();
		sig_tab_t tab;
		logic [63:0] h;
		logic [63:0] term;
		logic signed [63:0] sum;
		logic [63:0] q;
		logic [63:0] pw;
		logic [63:0] num;
		logic [63:0] g;
		int hi;
		int lo;
		tab = '0;
		h = (64'd8 << 32) / SIG_ENTRIES;
		term = 64'd1 << 32;
		sum = 64'sd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = udiv64((term * h) >> 32, 64'(k));
			if (k % 2 == 1) sum = sum - $signed(term);
			else sum = sum + $signed(term);
		end
		q = sum;
		pw = 64'd1 << 32;
		for (int m = 0; m < SIG_ENTRIES; m++) begin
			if (((SIG_ENTRIES - 1 + m) % 2) == 0) begin
				hi = (SIG_ENTRIES - 1 + m) / 2;
				lo = (SIG_ENTRIES - 1 - m) / 2;
				num = ((64'd1 << 32) - pw) << 15;
				g = udiv64(num, (64'd1 << 32) + pw);
				tab[hi] = g[31:0];
				tab[lo] = 32'(-g);
			end
			pw = (pw * q + 64'h8000_0000) >> 32;
		end
		return tab;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	// Saturate a 33-bit sum or difference to 32-bit signed.
	function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
		if (x[32] != x[31]) return {x[32], {31{~x[32]}}};
		return x[31:0];
	endfunction

	// Look up the centred sigmoid; arguments beyond the table use the end cells.
	function automatic logic signed [31:0] sig_lookup(input logic signed [31:0] x);
		logic signed [47:0] t;
		logic signed [47:0] idx_full;
		logic [SIG_IDX_W-1:0] idx;
		t = (48'(x) + 48'sd524288) * 48'(SIG_ENTRIES);
		idx_full = t >>> 20;
		if (idx_full < 0) idx = '0;
		else if (idx_full > 48'(SIG_ENTRIES - 1)) idx = SIG_IDX_W'(SIG_ENTRIES - 1);
		else idx = idx_full[SIG_IDX_W-1:0];
		return $signed(SIG_TABLE[idx]);
	endfunction

endpackage

// ===== design/ddwd_cfg.sv =====
// Configuration register file of the wheel dynamics block.
module ddwd_cfg (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [ddwd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddwd_pkg::CFG_DATA_W-1:0] cfg_data,
	output ddwd_pkg::cfg_t regs
);
	import ddwd_pkg::*;

	cfg_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.inv_wheel_radius <= 31'd65536;
			regs_q.wheel_radius <= 31'd65536;
			regs_q.half_track_width <= 31'd65536;
			regs_q.inv_track_width <= 31'd32768;
			regs_q.inv_torque_spread <= 31'd65536;
			regs_q.gain_left_left <= '0;
			regs_q.gain_left_right <= '0;
			regs_q.gain_right_right <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_WHEEL_RADIUS: regs_q.inv_wheel_radius <= cfg_data[30:0];
				REG_WHEEL_RADIUS: regs_q.wheel_radius <= cfg_data[30:0];
				REG_HALF_TRACK_WIDTH: regs_q.half_track_width <= cfg_data[30:0];
				REG_INV_TRACK_WIDTH: regs_q.inv_track_width <= cfg_data[30:0];
				REG_INV_TORQUE_SPREAD: regs_q.inv_torque_spread <= cfg_data[30:0];
				REG_GAIN_LEFT_LEFT: regs_q.gain_left_left <= $signed(cfg_data);
				REG_GAIN_LEFT_RIGHT: regs_q.gain_left_right <= $signed(cfg_data);
				REG_GAIN_RIGHT_RIGHT: regs_q.gain_right_right <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

// ===== design/ddwd_mul.sv =====
// Shared registered multiplier with Q16.16 rescale and 32-bit saturation.
module ddwd_mul (
	input  logic clk,
	input  logic en,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	input  logic sh17,
	output logic signed [31:0] res
);
	import ddwd_pkg::*;

	logic signed [65:0] product_q;
	logic sh17_q;
	logic signed [65:0] shifted;

	always_ff @(posedge clk) begin
		if (en) begin
			product_q <= 66'(a) * 66'(b);
			sh17_q <= sh17;
		end
	end

	// Arithmetic shift floors toward minus infinity.
	assign shifted = sh17_q ? (product_q >>> 17) : (product_q >>> 16);

	always_comb begin
		if (shifted[65:31] == '0 || shifted[65:31] == '1) res = shifted[31:0];
		else res = {shifted[65], {31{~shifted[65]}}};
	end

endmodule

// ===== design/diff_drive_wheel_dynamics_step.sv =====
// Top level of the differential-drive wheel dynamics block: sequencer and datapath.
//
// Channel  Direction  Handshake                Payload
// in       input      in_valid / in_ready      in_data  (velocity_cmd, turn_rate_cmd)
// out      output     out_valid / out_ready    out_data (velocity_out, turn_rate_out)
// cfg      input      cfg_we                   cfg_index, cfg_data
//
// Every product of an item comes from the single shared multiplier, whose product is
// registered. in_ready is high only while the sequencer is idle, so one item is finished
// before the next is taken.
// Asynchronous active-low reset clears the wheel rates, counter, state and out_valid.
// A result waiting on out_ready holds the sequencer in its last state.
module diff_drive_wheel_dynamics_step (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  ddwd_pkg::cmd_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output ddwd_pkg::res_t out_data,
	input  logic cfg_we,
	input  logic [ddwd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddwd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ddwd_pkg::*;

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_W = 4'd1;
	localparam logic [3:0] S_TL = 4'd2;
	localparam logic [3:0] S_TR = 4'd3;
	localparam logic [3:0] S_TRW = 4'd4;
	localparam logic [3:0] S_XL = 4'd5;
	localparam logic [3:0] S_XR = 4'd6;
	localparam logic [3:0] S_P1 = 4'd7;
	localparam logic [3:0] S_P2 = 4'd8;
	localparam logic [3:0] S_P3 = 4'd9;
	localparam logic [3:0] S_P4 = 4'd10;
	localparam logic [3:0] S_UPD = 4'd11;
	localparam logic [3:0] S_V = 4'd12;
	localparam logic [3:0] S_OM1 = 4'd13;
	localparam logic [3:0] S_OM2 = 4'd14;
	localparam logic [3:0] S_OUT = 4'd15;

	cfg_t regs;
	logic [3:0] state_q;
	logic [ITER_W-1:0] iter_q;
	cmd_t cmd_q;
	logic signed [31:0] left_q, right_q;
	logic signed [31:0] wh_q, tl_q, tr_q, gl_q, gr_q, p_q, il_q, vo_q;
	logic out_valid_q;
	res_t out_data_q;

	logic mul_en;
	logic mul_sh17;
	logic signed [32:0] mul_a, mul_b;
	logic signed [31:0] mul_res;
	logic signed [31:0] w_neg;
	logic out_free;

	ddwd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.regs(regs)
	);

	ddwd_mul u_mul (
		.clk(clk),
		.en(mul_en),
		.a(mul_a),
		.b(mul_b),
		.sh17(mul_sh17),
		.res(mul_res)
	);

	// The turn rate is taken in the opposite sense; the most negative value saturates.
	assign w_neg = sat33(-33'(cmd_q.turn_rate_cmd));
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// Operand selection for the shared multiplier in each state.
	always_comb begin
		mul_en = 1'b1;
		mul_sh17 = 1'b0;
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_W: begin
				mul_a = 33'(w_neg);
				mul_b = {2'b00, regs.half_track_width};
			end
			S_TL: begin
				mul_a = 33'(sat33(33'(cmd_q.velocity_cmd) - 33'(mul_res)));
				mul_b = {2'b00, regs.inv_wheel_radius};
			end
			S_TR: begin
				mul_a = 33'(sat33(33'(cmd_q.velocity_cmd) + 33'(wh_q)));
				mul_b = {2'b00, regs.inv_wheel_radius};
			end
			S_XL: begin
				mul_a = 33'(sat33(33'(tl_q) - 33'(left_q)));
				mul_b = {2'b00, regs.inv_torque_spread};
			end
			S_XR: begin
				mul_a = 33'(sat33(33'(tr_q) - 33'(right_q)));
				mul_b = {2'b00, regs.inv_torque_spread};
			end
			S_P1: begin
				mul_a = 33'(regs.gain_left_left);
				mul_b = 33'(gl_q);
			end
			S_P2: begin
				mul_a = 33'(regs.gain_left_right);
				mul_b = 33'(gr_q);
			end
			S_P3: begin
				mul_a = 33'(regs.gain_left_right);
				mul_b = 33'(gl_q);
			end
			S_P4: begin
				mul_a = 33'(regs.gain_right_right);
				mul_b = 33'(gr_q);
			end
			S_V: begin
				// Sum at full width, halved by the extra shift.
				mul_a = 33'(left_q) + 33'(right_q);
				mul_b = {2'b00, regs.wheel_radius};
				mul_sh17 = 1'b1;
			end
			S_OM1: begin
				mul_a = 33'(right_q) - 33'(left_q);
				mul_b = {2'b00, regs.wheel_radius};
			end
			S_OM2: begin
				mul_a = 33'(mul_res);
				mul_b = {2'b00, regs.inv_track_width};
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Sequencer and state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			iter_q <= '0;
			left_q <= '0;
			right_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// In the final state the result register is handled below.
			if (out_valid_q && out_ready && state_q != S_OUT) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_W;
				S_W: state_q <= S_TL;
				S_TL: state_q <= S_TR;
				S_TR: state_q <= S_TRW;
				S_TRW: state_q <= S_XL;
				S_XL: state_q <= S_XR;
				S_XR: state_q <= S_P1;
				S_P1: state_q <= S_P2;
				S_P2: state_q <= S_P3;
				S_P3: state_q <= S_P4;
				S_P4: state_q <= S_UPD;
				S_UPD: begin
					left_q <= sat33(33'(left_q) + 33'(il_q));
					right_q <= sat33(33'(right_q) +
						33'(sat33(33'(p_q) + 33'(mul_res))));
					if (iter_q == ITER_W'(ITERATIONS - 1)) begin
						iter_q <= '0;
						state_q <= S_V;
					end else begin
						iter_q <= iter_q + 1'b1;
						state_q <= S_XL;
					end
				end
				S_V: state_q <= S_OM1;
				S_OM1: state_q <= S_OM2;
				S_OM2: state_q <= S_OUT;
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_valid) cmd_q <= in_data;
			S_TL: wh_q <= mul_res;
			S_TR: tl_q <= mul_res;
			S_TRW: tr_q <= mul_res;
			S_XR: gl_q <= sig_lookup(mul_res);
			S_P1: gr_q <= sig_lookup(mul_res);
			S_P2: p_q <= mul_res;
			S_P3: il_q <= sat33(33'(p_q) + 33'(mul_res));
			S_P4: p_q <= mul_res;
			S_OM1: vo_q <= mul_res;
			S_OUT: begin
				if (out_free) begin
					out_data_q.velocity_out <= vo_q;
					out_data_q.turn_rate_out <= sat33(-33'(mul_res));
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	// A new item is never taken in the cycle after one was accepted.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while sequencer busy");

	// A result appears only on leaving the final state.
	a_result_from_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_OUT)
		else $error("result raised outside final state");

	// The substep counter stays in range.
	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q < ITER_W'(ITERATIONS))
		else $error("substep counter out of range");

	// The counter is back at zero whenever the sequencer is idle.
	a_iter_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> iter_q == '0)
		else $error("substep counter not cleared at idle");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the differential-drive wheel dynamics block.
`timescale 1ns / 1ps

module tb_top;
	import ddwd_pkg::*;

	// Row kinds of the directed stimulus table.
	typedef enum logic {ROW_WRITE, ROW_CMD} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [31:0]         reg_val;
		cmd_t                cmd;
		bit                  typed;
		res_t                typed_res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	cmd_t in_data;
	logic out_valid;
	logic out_ready;
	res_t out_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	diff_drive_wheel_dynamics_step uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// The predictor's own copy of the registers, the wheel rates and the sigmoid cells.
	longint torque_cell [SIG_ENTRIES];
	longint inv_radius, radius_mm, half_track, inv_track, inv_spread;
	longint g_ll, g_lr, g_rr;
	longint rate_left, rate_right;

	// Predicted motion per accepted item, plus a hand-typed value where the table gives one.
	res_t predicted_motion[$];
	bit   typed_flag[$];
	res_t typed_motion[$];

	// The sender publishes whether the item on offer carries a hand-typed result.
	bit   offer_typed;
	res_t offer_res;

	int errors;
	int results_seen;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Generous fixed time limit for the whole run; reaching it reports a failure.
	initial begin
		#20_000_000;
		$display("diff_drive_wheel_dynamics_step verification failed");
		$finish;
	end

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// Q16.16 product, floored and saturated.
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	// Cells span [-8, 8) and hold s(c) - 0.5; the exponential comes from a truncated series.
	function automatic void build_torque_cells();
		longint unsigned step_h, term, ratio, pw, num, g;
		longint sum;
		int hi, lo;
		step_h = (64'd8 << 32) / SIG_ENTRIES;
		term = 64'd1 << 32;
		sum = 64'sd1 << 32;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * step_h) >> 32) / k;
			if (k % 2 == 1) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		ratio = longint'(sum);
		pw = 64'd1 << 32;
		for (int m = 0; m < SIG_ENTRIES; m++) begin
			if (((SIG_ENTRIES - 1 + m) % 2) == 0) begin
				hi = (SIG_ENTRIES - 1 + m) / 2;
				lo = (SIG_ENTRIES - 1 - m) / 2;
				num = ((64'd1 << 32) - pw) << 15;
				g = num / ((64'd1 << 32) + pw);
				torque_cell[hi] = longint'(g);
				torque_cell[lo] = -longint'(g);
			end
			pw = (pw * ratio + 64'h8000_0000) >> 32;
		end
	endfunction

	function automatic longint torque_of(longint x);
		longint idx;
		idx = ((x + (64'sd8 << 16)) * SIG_ENTRIES) >>> 20;
		if (idx < 0) idx = 0;
		if (idx > SIG_ENTRIES - 1) idx = SIG_ENTRIES - 1;
		return torque_cell[idx];
	endfunction

	function automatic void reset_dynamics();
		inv_radius = 65536;
		radius_mm = 65536;
		half_track = 65536;
		inv_track = 32768;
		inv_spread = 65536;
		g_ll = 0;
		g_lr = 0;
		g_rr = 0;
		rate_left = 0;
		rate_right = 0;
		build_torque_cells();
	endfunction

	function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		longint u;
		longint s;
		u = longint'(val[30:0]);
		s = longint'($signed(val));
		case (idx)
			REG_INV_WHEEL_RADIUS: inv_radius = u;
			REG_WHEEL_RADIUS: radius_mm = u;
			REG_HALF_TRACK_WIDTH: half_track = u;
			REG_INV_TRACK_WIDTH: inv_track = u;
			REG_INV_TORQUE_SPREAD: inv_spread = u;
			REG_GAIN_LEFT_LEFT: g_ll = s;
			REG_GAIN_LEFT_RIGHT: g_lr = s;
			REG_GAIN_RIGHT_RIGHT: g_rr = s;
			default: ;
		endcase
	endfunction

	// Advances the wheel rates through all substeps and returns the resulting motion.
	function automatic res_t advance_wheels(cmd_t c);
		longint v, w, wh, tgt_l, tgt_r, tq_l, tq_r, inc_l, inc_r, vo, om;
		res_t r;
		v = longint'(c.velocity_cmd);
		w = clamp32(-longint'(c.turn_rate_cmd));
		wh = qmul(w, half_track);
		tgt_l = qmul(clamp32(v - wh), inv_radius);
		tgt_r = qmul(clamp32(v + wh), inv_radius);
		for (int i = 0; i < ITERATIONS; i++) begin
			tq_l = torque_of(qmul(clamp32(tgt_l - rate_left), inv_spread));
			tq_r = torque_of(qmul(clamp32(tgt_r - rate_right), inv_spread));
			inc_l = clamp32(qmul(g_ll, tq_l) + qmul(g_lr, tq_r));
			inc_r = clamp32(qmul(g_lr, tq_l) + qmul(g_rr, tq_r));
			rate_left = clamp32(rate_left + inc_l);
			rate_right = clamp32(rate_right + inc_r);
		end
		vo = clamp32(((rate_left + rate_right) * radius_mm) >>> 17);
		om = qmul(clamp32(((rate_right - rate_left) * radius_mm) >>> 16), inv_track);
		om = clamp32(-om);
		r.velocity_out = vo[31:0];
		r.turn_rate_out = om[31:0];
		return r;
	endfunction

	// Watches all three ports at the rising edge. Values read here are those before the edge.
	always @(posedge clk) begin
		res_t want;
		res_t hand;
		bit has_hand;
		if (arst_n) begin
			if (cfg_we) apply_register(cfg_index, cfg_data);
			if (in_valid && in_ready) begin
				predicted_motion.push_back(advance_wheels(in_data));
				typed_flag.push_back(offer_typed);
				typed_motion.push_back(offer_res);
			end
			if (out_valid && out_ready) begin
				results_seen++;
				if (predicted_motion.size() == 0) begin
					$error("result with nothing expected: velocity_out %0d turn_rate_out %0d",
						out_data.velocity_out, out_data.turn_rate_out);
					errors++;
				end else begin
					want = predicted_motion.pop_front();
					has_hand = typed_flag.pop_front();
					hand = typed_motion.pop_front();
					// A typed row's value is checked against the predictor, as is the block's output.
					if (has_hand && hand != want) begin
						$error("predictor disagrees with typed row: expected %0d/%0d, got %0d/%0d",
							hand.velocity_out, hand.turn_rate_out,
							want.velocity_out, want.turn_rate_out);
						errors++;
					end
					if (out_data.velocity_out !== want.velocity_out) begin
						$error("velocity_out: expected %0d, actual %0d",
							want.velocity_out, out_data.velocity_out);
						errors++;
					end
					if (out_data.turn_rate_out !== want.turn_rate_out) begin
						$error("turn_rate_out: expected %0d, actual %0d",
							want.turn_rate_out, out_data.turn_rate_out);
						errors++;
					end
				end
			end
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 55) return 0;
		if (roll < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, with one long hold-off so the block fills and blocks its input.
	initial begin
		int gap;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 200) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(negedge clk);
			end
			gap = pick_gap();
			if (gap == 0 || $urandom_range(3) == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	// Entered at a falling edge; returns at a falling edge once the item is taken and any gap
	// has passed. With no gap, valid stays high into the next item.
	task automatic offer_cmd(cmd_t c, bit typed, res_t hand);
		int gap;
		in_valid <= 1'b1;
		in_data <= c;
		offer_typed = typed;
		offer_res = hand;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Pause the sender until every expected item has come back, then let the block settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (predicted_motion.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] rand_cmd_field();
		int roll;
		roll = $urandom_range(99);
		if (roll < 50) return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		if (roll < 75) return $urandom();
		if (roll < 85) begin
			case ($urandom_range(3))
				0: return 32'h7FFF_FFFF;
				1: return 32'h8000_0000;
				2: return 32'hFFFF_FFFF;
				default: return 32'h0000_0000;
			endcase
		end
		return 32'($signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200);
	endfunction

	// One register setting: modes 0 and 1 fixed extremes, 2 wide random, else plain random.
	task automatic program_setting(int mode);
		logic [31:0] val [8];
		for (int i = 0; i < 8; i++) begin
			case (mode)
				0: val[i] = (i < 5) ? 32'h0000_0000 : 32'h8000_0000;
				1: val[i] = (i < 5) ? 32'hFFFF_FFFF : 32'h7FFF_FFFF;
				2: val[i] = $urandom();
				default: val[i] = (i < 5) ? $urandom_range(32'h0000_4000, 32'h0004_0000)
					: 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			endcase
		end
		for (int i = 0; i < 8; i++) write_reg(i[CFG_IDX_W-1:0], val[i]);
	endtask

	stim_row_t directed [];

	function automatic stim_row_t cmd_row(logic [31:0] v, logic [31:0] w);
		stim_row_t r;
		r.kind = ROW_CMD;
		r.reg_idx = REG_INV_WHEEL_RADIUS;
		r.reg_val = '0;
		r.cmd.velocity_cmd = v;
		r.cmd.turn_rate_cmd = w;
		r.typed = 1'b0;
		r.typed_res = '0;
		return r;
	endfunction

	// With the reset gains of zero the wheels never move, so the motion is plainly zero.
	function automatic stim_row_t zero_row(logic [31:0] v, logic [31:0] w);
		stim_row_t r;
		r = cmd_row(v, w);
		r.typed = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		stim_row_t r;
		r = cmd_row('0, '0);
		r.kind = ROW_WRITE;
		r.reg_idx = idx;
		r.reg_val = val;
		return r;
	endfunction

	initial begin
		cmd_t c;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		offer_typed = 1'b0;
		offer_res = '0;
		errors = 0;
		results_seen = 0;
		reset_dynamics();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed = '{
			zero_row(32'h0000_0000, 32'h0000_0000),
			// Most negative turn rate: its negation saturates.
			zero_row(32'h7FFF_FFFF, 32'h8000_0000),
			zero_row(32'h8000_0000, 32'h7FFF_FFFF),
			reg_row(REG_INV_WHEEL_RADIUS, 32'h0000_8000),
			reg_row(REG_WHEEL_RADIUS, 32'h0002_0000),
			reg_row(REG_HALF_TRACK_WIDTH, 32'h0000_C000),
			reg_row(REG_INV_TRACK_WIDTH, 32'h0000_AAAA),
			reg_row(REG_INV_TORQUE_SPREAD, 32'h0000_8000),
			reg_row(REG_GAIN_LEFT_LEFT, 32'h0001_0000),
			reg_row(REG_GAIN_LEFT_RIGHT, 32'hFFFF_C000),
			reg_row(REG_GAIN_RIGHT_RIGHT, 32'h0001_0000),
			cmd_row(32'h0002_0000, 32'h0000_0000),
			cmd_row(32'h0002_0000, 32'h0001_0000),
			cmd_row(32'hFFFE_0000, 32'hFFFF_0000),
			cmd_row(32'h7FFF_FFFF, 32'h7FFF_FFFF),
			cmd_row(32'h8000_0000, 32'h8000_0000),
			// Top bit of an unsigned register is dropped; a huge spread drives x off the table.
			reg_row(REG_INV_TORQUE_SPREAD, 32'hFFFF_FFFF),
			reg_row(REG_WHEEL_RADIUS, 32'hFFFF_FFFF),
			reg_row(REG_GAIN_LEFT_LEFT, 32'h7FFF_FFFF),
			reg_row(REG_GAIN_LEFT_RIGHT, 32'h8000_0000),
			reg_row(REG_GAIN_RIGHT_RIGHT, 32'h7FFF_FFFF),
			cmd_row(32'h7FFF_FFFF, 32'h0000_0000),
			cmd_row(32'h8000_0000, 32'h7FFF_FFFF),
			cmd_row(32'h0000_0001, 32'hFFFF_FFFF),
			cmd_row(32'h0000_0000, 32'h8000_0000)
		};

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed[i].reg_idx, directed[i].reg_val);
			end else begin
				offer_cmd(directed[i].cmd, directed[i].typed, directed[i].typed_res);
			end
		end

		// Random phases: the extremes first, then a mix of plain and wide settings.
		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			if (phase < 2) program_setting(phase);
			else program_setting((phase % 3 == 0) ? 2 : 3);
			for (int n = 0; n < 143; n++) begin
				c.velocity_cmd = rand_cmd_field();
				c.turn_rate_cmd = rand_cmd_field();
				offer_cmd(c, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (predicted_motion.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0) begin
			$display("diff_drive_wheel_dynamics_step verification clean");
		end else begin
			$display("diff_drive_wheel_dynamics_step verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/ddwd_pkg.sv
design/ddwd_cfg.sv
design/ddwd_mul.sv
design/diff_drive_wheel_dynamics_step.sv
bench/tb_top.sv
